// File: design/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, ignored while reset is asserted.
`define BNC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked property for logic that has no reset.
`define BNC_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BNC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BNC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: design/bnc_pkg.sv
// Types, constants and helpers for the BGRA to NV12 converter.
package bnc_pkg;

	localparam int CFG_W     = 13;
	localparam int COUNT_W   = 12;
	localparam int REG_IDX_W = 1;
	localparam int LINE_W    = 18;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;
	localparam int               HEIGHT_LIMIT = 4096;

	// BT.601 coefficients, magnitudes; signs are applied in the datapath
	localparam logic [15:0] Y_R = 16'd66;
	localparam logic [15:0] Y_G = 16'd129;
	localparam logic [15:0] Y_B = 16'd25;
	localparam logic [15:0] U_R = 16'd38;
	localparam logic [15:0] U_G = 16'd74;
	localparam logic [15:0] U_B = 16'd112;
	localparam logic [15:0] V_R = 16'd112;
	localparam logic [15:0] V_G = 16'd94;
	localparam logic [15:0] V_B = 16'd18;
	localparam logic [15:0] ROUND   = 16'd128;
	// rounding plus 128 << 8, keeps the chroma sums positive
	localparam logic [15:0] UV_BIAS = 16'd32896;

	localparam logic [7:0] Y_OFFSET = 8'd16;
	localparam logic [7:0] LUMA_MIN = 8'd16;
	localparam logic [7:0] LUMA_MAX = 8'd235;

	typedef struct packed {
		logic [7:0] v;
		logic [7:0] u;
		logic [7:0] y;
	} yuv_t;

	typedef struct packed {
		logic col_odd;
		logic row_odd;
		logic frame_end;
	} pos_t;

	// clamp to 2..hi, then round down to even
	function automatic logic [CFG_W-1:0] fit_even(input logic [CFG_W-1:0] v,
			input logic [CFG_W:0] hi);
		logic [CFG_W:0] t;
		t = {1'b0, v};
		if (t < 14'd2) t = 14'd2;
		if (t > hi) t = hi;
		t[0] = 1'b0;
		return t[CFG_W-1:0];
	endfunction

endpackage

// File: design/bnc_csc.sv
// Color space conversion of one pixel to 8-bit Y, U and V.
module bnc_csc (
	input  logic [7:0]   red,
	input  logic [7:0]   green,
	input  logic [7:0]   blue,
	output bnc_pkg::yuv_t yuv
);
	import bnc_pkg::*;

	logic [15:0] r16, g16, b16;
	logic [15:0] y_sum, u_sum, v_sum;

	assign r16 = {8'd0, red};
	assign g16 = {8'd0, green};
	assign b16 = {8'd0, blue};

	// all three sums stay within 0..65535 after the bias, so mod 2^16 is exact
	assign y_sum = Y_R * r16 + Y_G * g16 + Y_B * b16 + ROUND;
	assign u_sum = U_B * b16 + UV_BIAS - U_R * r16 - U_G * g16;
	assign v_sum = V_R * r16 + UV_BIAS - V_G * g16 - V_B * b16;

	assign yuv.y = y_sum[15:8];
	assign yuv.u = u_sum[15:8];
	assign yuv.v = v_sum[15:8];

endmodule

// File: design/bnc_line_mem.sv
// Line store of even-row chroma pair sums, one read and one write port.
`include "assert_macros.svh"
module bnc_line_mem #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [bnc_pkg::LINE_W-1:0] wr_data,
	output logic [bnc_pkg::LINE_W-1:0] rd_data
);
	import bnc_pkg::*;

	logic [LINE_W-1:0] mem [DEPTH];
	logic [LINE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-first: a same-cycle write to the read address is bypassed
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

	`BNC_ASSERT_NR(a_bypass, clk, (rd_en && wr_en && rd_addr == wr_addr) |=> (rd_data == $past(wr_data)), "line store bypass lost a write")

endmodule

// File: design/bnc_position.sv
// Frame geometry registers, pixel position counters and line store slot.
`include "assert_macros.svh"
module bnc_position #(
	parameter int MAX_WIDTH  = 4096,
	parameter int LINE_DEPTH = 2048,
	parameter int SLOT_W     = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bnc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bnc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          advance,
	output bnc_pkg::pos_t                 pos,
	output logic [SLOT_W-1:0]             slot
);
	import bnc_pkg::*;

	localparam logic [CFG_W:0]    WIDTH_HI  = (CFG_W+1)'(MAX_WIDTH);
	localparam logic [CFG_W:0]    HEIGHT_HI = (CFG_W+1)'(HEIGHT_LIMIT);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINE_DEPTH - 1);

	logic [CFG_W-1:0]   width_q, height_q;
	logic [COUNT_W-1:0] col_q, row_q, col_inc;
	logic [SLOT_W-1:0]  slot_q, slot_nxt;
	logic               last_col, last_row;

	// geometry is stored already clamped and even
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fit_even(WIDTH_RESET, WIDTH_HI);
			height_q <= fit_even(HEIGHT_RESET, HEIGHT_HI);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= fit_even(cfg_data, WIDTH_HI);
				REG_FRAME_HEIGHT: height_q <= fit_even(cfg_data, HEIGHT_HI);
			endcase
		end
	end

	assign col_inc  = col_q + 12'd1;
	assign last_col = ({1'b0, col_q} + 13'd1) >= width_q;
	assign last_row = ({1'b0, row_q} + 13'd1) >= height_q;

	// slot tracks (col >> 1) mod LINE_DEPTH without a divider
	always_comb begin
		priority if (last_col) begin
			slot_nxt = '0;
		end else if (col_inc == '0) begin
			slot_nxt = '0;
		end else if (!col_inc[0]) begin
			slot_nxt = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
		end else begin
			slot_nxt = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (advance) begin
			slot_q <= slot_nxt;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_inc;
			end
		end
	end

	assign pos.col_odd   = col_q[0];
	assign pos.row_odd   = row_q[0];
	assign pos.frame_end = last_col & last_row;
	assign slot          = slot_q;

	`BNC_ASSERT(a_frame_wrap, clk, arst_n, (advance && last_col && last_row) |=> (col_q == '0 && row_q == '0 && slot_q == '0), "position did not wrap at frame end")

endmodule

// File: design/bgra_to_nv12_converter.sv
// Top level: BGRA pixel stream to NV12 luma plus 2x2 averaged chroma.
//
//  channel | dir | handshake        | contents
//  s_      | in  | tvalid/tready    | tdata: blue, green, red
//  m_      | out | tvalid/tready    | tdata: luma, chroma_u, chroma_v; tuser: chroma_valid;
//          |     |                  | tlast: frame_end
//  cfg_    | in  | we (no wait)     | index 0 frame_width, 1 frame_height
//
// One pixel per clock while m_tready allows; path: stage 1, stage 2, output register.
// The rate is set by the line store: one read and one write port, each used at most once per pixel.
// Each stage loads when empty or draining, so input is taken while a result waits.
// Reset clears positions and valid flags and restores the reset geometry; the line store is not cleared.
`include "assert_macros.svh"
module bgra_to_nv12_converter #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // blue[7:0], green[15:8], red[23:16]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // luma[7:0], chroma_u[15:8], chroma_v[23:16]
	output logic                          m_tuser,   // chroma_valid
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [bnc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bnc_pkg::CFG_W-1:0]     cfg_data
);
	import bnc_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic              en1, en2, en_o, accept, s2_leave;
	pos_t              pos_cur, pos_s1, pos_s2;
	logic [SLOT_W-1:0] slot_cur, slot_s1, slot_s2;
	logic              v1_q, v2_q, ov_q;
	logic [7:0]        red_s1, green_s1, blue_s1;
	yuv_t              yuv_cur, yuv_s2;
	logic [7:0]        pair_u_q, pair_v_q;
	logic [8:0]        su, sv;
	logic [9:0]        tu, tv;
	logic              mem_rd, mem_wr;
	logic [LINE_W-1:0] line_rd;
	logic [7:0]        luma_q, cu_q, cv_q;
	logic              cvalid_q, fend_q;

	assign en_o     = !ov_q || m_tready;
	assign en2      = !v2_q || en_o;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && en1;
	assign s2_leave = v2_q && en_o;

	bnc_position #(
		.MAX_WIDTH (MAX_WIDTH),
		.LINE_DEPTH(LINE_DEPTH),
		.SLOT_W    (SLOT_W)
	) u_position (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (accept),
		.pos      (pos_cur),
		.slot     (slot_cur)
	);

	// stage 1: captured pixel and its position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (en1) begin
			v1_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_s1  <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			red_s1   <= s_tdata[23:16];
			pos_s1   <= pos_cur;
			slot_s1  <= slot_cur;
		end
	end

	bnc_csc u_csc (
		.red  (red_s1),
		.green(green_s1),
		.blue (blue_s1),
		.yuv  (yuv_cur)
	);

	// stage 2: converted pixel; line store read issued on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (en2) begin
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			yuv_s2  <= yuv_cur;
			pos_s2  <= pos_s1;
			slot_s2 <= slot_s1;
		end
	end

	assign mem_rd = v1_q && en2 && pos_s1.col_odd && pos_s1.row_odd;
	assign mem_wr = s2_leave && pos_s2.col_odd && !pos_s2.row_odd;

	assign su = {1'b0, pair_u_q} + {1'b0, yuv_s2.u};
	assign sv = {1'b0, pair_v_q} + {1'b0, yuv_s2.v};
	assign tu = {1'b0, su} + {1'b0, line_rd[17:9]};
	assign tv = {1'b0, sv} + {1'b0, line_rd[8:0]};

	bnc_line_mem #(
		.DEPTH (LINE_DEPTH),
		.ADDR_W(SLOT_W)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (mem_rd),
		.rd_addr(slot_s1),
		.wr_en  (mem_wr),
		.wr_addr(slot_s2),
		.wr_data({su, sv}),
		.rd_data(line_rd)
	);

	// even-column pixel of a pair waits here for its partner
	always_ff @(posedge clk) begin
		if (s2_leave && !pos_s2.col_odd) begin
			pair_u_q <= yuv_s2.u;
			pair_v_q <= yuv_s2.v;
		end
	end

	// output register; luma tops out at 235 and the block average at 240, no clamp needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en_o) begin
			ov_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_leave) begin
			luma_q   <= yuv_s2.y + Y_OFFSET;
			cvalid_q <= pos_s2.col_odd && pos_s2.row_odd;
			cu_q     <= (pos_s2.col_odd && pos_s2.row_odd) ? tu[9:2] : 8'd0;
			cv_q     <= (pos_s2.col_odd && pos_s2.row_odd) ? tv[9:2] : 8'd0;
			fend_q   <= pos_s2.frame_end;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {cv_q, cu_q, luma_q};
	assign m_tuser  = cvalid_q;
	assign m_tlast  = fend_q;

	`BNC_ASSERT(a_accept_fills, clk, arst_n, (s_tvalid && s_tready) |=> v1_q, "accepted item not in stage 1")
	`BNC_ASSERT(a_chroma_zero, clk, arst_n, (ov_q && !cvalid_q) |-> (cu_q == 8'd0 && cv_q == 8'd0), "chroma set without a completed block")
	`BNC_ASSERT(a_luma_range, clk, arst_n, ov_q |-> (luma_q >= LUMA_MIN && luma_q <= LUMA_MAX), "luma outside studio range")

endmodule

// File: tb/sv/tb.sv
// Testbench for the BGRA to NV12 converter: directed table, then random frames.
module tb;
	import bnc_pkg::*;

	localparam int MAX_W        = 4096;
	localparam int LINE_SLOTS   = MAX_W / 2;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1100;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       frame_end;
	} nv12_t;

	typedef struct {
		bit                   is_reg;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		logic [7:0]           blue;
		logic [7:0]           green;
		logic [7:0]           red;
		bit                   pinned;
		nv12_t                want;
	} step_t;

	typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [23:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// converter state as the checker sees it
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [11:0]      col_pos;
	logic [11:0]      row_pos;
	logic [8:0]       even_u;
	logic [8:0]       even_v;
	logic [17:0]      pair_line [LINE_SLOTS];

	nv12_t    nv12_due[$];
	step_t    directed[$];
	int       mismatch_count = 0;
	int       quiet_cycles = 0;
	int       pixels_sent = 0;
	bit       pin_on = 1'b0;
	nv12_t    pin_want;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bgra_to_nv12_converter #(.MAX_WIDTH(MAX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic int even_fit(input logic [CFG_W-1:0] v, input int hi);
		int t;
		t = v;
		if (t < 2) t = 2;
		if (t > hi) t = hi;
		return t & ~1;
	endfunction

	function automatic logic [7:0] to_byte(input int x);
		if (x < 0) return 8'd0;
		if (x > 255) return 8'd255;
		return x[7:0];
	endfunction

	// one pixel through the converter; advances the position and line store
	function automatic nv12_t convert_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		int          bi, gi, ri, w, h, y, u, v, tu, tv;
		logic [10:0] slot;
		logic [8:0]  su, sv;
		logic        last_col, last_row;
		nv12_t       o;
		bi = b;
		gi = g;
		ri = r;
		w = even_fit(width_reg, MAX_W);
		h = even_fit(height_reg, HEIGHT_LIMIT);
		y = (66 * ri + 129 * gi + 25 * bi + 128) >>> 8;
		u = (-38 * ri - 74 * gi + 112 * bi + 128 + 32768) >>> 8;
		v = (112 * ri - 94 * gi - 18 * bi + 128 + 32768) >>> 8;
		o = '0;
		slot = col_pos[11:1];
		if (!col_pos[0]) begin
			even_u = u[8:0];
			even_v = v[8:0];
		end else begin
			su = even_u + u[8:0];
			sv = even_v + v[8:0];
			if (!row_pos[0]) begin
				pair_line[slot] = {su, sv};
			end else begin
				tu = su + pair_line[slot][17:9];
				tv = sv + pair_line[slot][8:0];
				o.chroma_u = to_byte(tu >>> 2);
				o.chroma_v = to_byte(tv >>> 2);
				o.chroma_valid = 1'b1;
			end
		end
		// positions past the frame (after a mid-frame register change) end the row or frame
		last_col = (col_pos + 1 >= w);
		last_row = (row_pos + 1 >= h);
		if (last_col) begin
			col_pos = '0;
			row_pos = last_row ? 12'd0 : row_pos + 12'd1;
		end else begin
			col_pos = col_pos + 12'd1;
		end
		o.luma = to_byte(y + 16);
		o.frame_end = last_col & last_row;
		return o;
	endfunction

	function automatic logic [7:0] rand_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input bit pinned, input nv12_t want);
		step_t s;
		s.is_reg = 1'b0;
		s.reg_idx = '0;
		s.reg_val = '0;
		s.blue = b;
		s.green = g;
		s.red = r;
		s.pinned = pinned;
		s.want = want;
		directed.insert(directed.size(), s);
	endfunction

	function automatic void add_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		step_t s;
		s.is_reg = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		s.blue = '0;
		s.green = '0;
		s.red = '0;
		s.pinned = 1'b0;
		s.want = '0;
		directed.insert(directed.size(), s);
	endfunction

	// checker and watchdog
	always @(posedge clk) begin
		nv12_t got;
		nv12_t exp_r;
		bit    hit;
		hit = 1'b0;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos = '0;
			row_pos = '0;
			even_u = '0;
			even_v = '0;
			nv12_due.delete();
		end else begin
			if (cfg_we) begin
				hit = 1'b1;
				if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
				else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				hit = 1'b1;
				exp_r = convert_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
				nv12_due.insert(nv12_due.size(), pin_on ? pin_want : exp_r);
			end
			if (m_tvalid && m_tready) begin
				hit = 1'b1;
				got = {m_tdata[7:0], m_tuser, m_tdata[15:8], m_tdata[23:16], m_tlast};
				if (nv12_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected item: luma %0d cv %0b u %0d v %0d last %0b",
							got.luma, got.chroma_valid, got.chroma_u, got.chroma_v,
							got.frame_end);
				end else begin
					exp_r = nv12_due.pop_front();
					if (got !== exp_r) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: exp luma %0d cv %0b u %0d v %0d last %0b, %s",
								exp_r.luma, exp_r.chroma_valid, exp_r.chroma_u,
								exp_r.chroma_v, exp_r.frame_end,
								$sformatf("got luma %0d cv %0b u %0d v %0d last %0b",
									got.luma, got.chroma_valid, got.chroma_u,
									got.chroma_v, got.frame_end));
					end
				end
			end
		end
		quiet_cycles = hit ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// output backpressure: modes of random length
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(4, 60);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_tready <= (rx_tick % 3 != 0);
			default:     m_tready <= (rx_left % 8 == 0);
		endcase
	end

	// all sender tasks start and end at a falling edge
	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input bit pinned, input nv12_t want);
		pin_on = pinned;
		pin_want = want;
		s_tvalid <= 1'b1;
		s_tdata <= {r, g, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (nv12_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && count > 0) begin
				push_pixel(rand_level(), rand_level(), rand_level(), 1'b0, '0);
				burst--;
				count--;
				pixels_sent++;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: ;
				3: wait_drained();
				default: hold_off($urandom_range(1, 6));
			endcase
		end
	endtask

	// whole frames only, so each phase starts and ends at the top of a frame
	task automatic run_frames(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int frames);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		send_random(even_fit(w, MAX_W) * even_fit(h, HEIGHT_LIMIT) * frames);
	endtask

	initial begin
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// row 0 at the reset geometry: black, white, blue, red
		add_pixel(8'd0, 8'd0, 8'd0, 1'b1, {8'd16, 1'b0, 8'd0, 8'd0, 1'b0});
		add_pixel(8'd255, 8'd255, 8'd255, 1'b1, {8'd235, 1'b0, 8'd0, 8'd0, 1'b0});
		add_pixel(8'd255, 8'd0, 8'd0, 1'b1, {8'd41, 1'b0, 8'd0, 8'd0, 1'b0});
		add_pixel(8'd0, 8'd0, 8'd255, 1'b1, {8'd82, 1'b0, 8'd0, 8'd0, 1'b0});
		// narrowing mid-row: column 4 now lies past the row end
		add_reg(REG_FRAME_WIDTH, 13'd4);
		add_pixel(8'd0, 8'd255, 8'd0, 1'b1, {8'd144, 1'b0, 8'd0, 8'd0, 1'b0});
		add_reg(REG_FRAME_HEIGHT, 13'd2);
		// row 1 repeats row 0, so each block averages to the pair sums
		add_pixel(8'd0, 8'd0, 8'd0, 1'b1, {8'd16, 1'b0, 8'd0, 8'd0, 1'b0});
		add_pixel(8'd255, 8'd255, 8'd255, 1'b1, {8'd235, 1'b1, 8'd128, 8'd128, 1'b0});
		add_pixel(8'd255, 8'd0, 8'd0, 1'b1, {8'd41, 1'b0, 8'd0, 8'd0, 1'b0});
		add_pixel(8'd0, 8'd0, 8'd255, 1'b1, {8'd82, 1'b1, 8'd165, 8'd175, 1'b1});
		// below-range geometry clamps to 2x2
		add_reg(REG_FRAME_WIDTH, 13'd0);
		add_reg(REG_FRAME_HEIGHT, 13'd1);
		add_pixel(8'd255, 8'd0, 8'd255, 1'b0, '0);
		add_pixel(8'd0, 8'd255, 8'd0, 1'b0, '0);
		add_pixel(8'd0, 8'd255, 8'd255, 1'b0, '0);
		add_pixel(8'd255, 8'd0, 8'd0, 1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				wait_drained();
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				push_pixel(directed[i].blue, directed[i].green, directed[i].red,
					directed[i].pinned, directed[i].want);
			end
		end

		// widest row from an above-range width, cut short: column 64 then ends row 0
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd8191);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_random(64);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd2);
		send_random(1 + 2);

		// tallest frame from an above-range height, cut short: row 32 closes the frame
		run_frames(13'd2, 13'd8191, 0);
		send_random(2 * 32);
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_random(2);

		run_frames(13'd7, 13'd3, 2);

		// shrink height while on row 4: that row closes the frame
		run_frames(13'd8, 13'd8, 0);
		send_random(32);
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_random(8 + 16);

		while (pixels_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: w = 13'($urandom_range(0, 1));
				1: w = 13'(2 * $urandom_range(1, 20) + 1);
				default: w = 13'(2 * $urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 7))
				0: h = 13'($urandom_range(0, 1));
				1: h = 13'(2 * $urandom_range(1, 6) + 1);
				default: h = 13'(2 * $urandom_range(1, 6));
			endcase
			run_frames(w, h, $urandom_range(1, 2));
		end

		wait_drained();
		if (mismatch_count == 0 && nv12_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
